// File: src/stbl_pkg.sv
package stbl_pkg;

  // Defaults for the table geometry
  localparam int MAX_FEATURES = 16;
  localparam int MAX_SPLITS   = 64;

  // Fixed field widths
  localparam int CFG_W   = 7;   // splits_in_use register
  localparam int IDX_W   = 7;   // search bounds never exceed splits_in_use
  localparam int ROW_W   = 4;   // feature field
  localparam int SLOT_W  = 6;
  localparam int BIN_W   = 8;
  localparam int VALUE_W = 32;

  // One in Q16.16 and the largest positive value
  localparam logic signed [VALUE_W-1:0] Q_ONE   = 32'sh0001_0000;
  localparam logic signed [VALUE_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [BIN_W-1:0]   BIN_NAN = -8'sd1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_BIN   = 2'd1,
    CMD_VALUE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Request beat
  typedef struct packed {
    cmd_e                      cmd;
    logic [ROW_W-1:0]          feature;
    logic [SLOT_W-1:0]         slot;
    logic signed [BIN_W-1:0]   bin_in;
    logic signed [VALUE_W-1:0] value;
    logic                      value_missing;
  } req_t;

  // Result beat
  typedef struct packed {
    logic signed [BIN_W-1:0]   bin_out;
    logic signed [VALUE_W-1:0] value_out;
    logic                      value_is_nan;
    status_e                   status;
  } res_t;

  // Item as it travels down the pipeline
  typedef struct packed {
    cmd_e                      cmd;
    logic [ROW_W-1:0]          row;
    logic [SLOT_W-1:0]         slot;
    logic                      wr_ok;
    logic signed [BIN_W-1:0]   bin_in;
    logic signed [VALUE_W-1:0] value;
    logic                      missing;
    logic [IDX_W-1:0]          n;
    logic [IDX_W-1:0]          lo;
    logic [IDX_W-1:0]          hi;
    logic                      over;      // value above the last split
    logic signed [VALUE_W-1:0] val_res;   // answer for a value-from-bin beat
    logic                      nan;
    status_e                   status;
  } item_t;

endpackage

// File: src/stbl_ram.sv
module stbl_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/stbl_stage.sv
module stbl_stage import stbl_pkg::*; #(
  parameter int MaxFeatures = MAX_FEATURES,
  parameter int MaxSplits   = MAX_SPLITS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int Depth = MaxFeatures * MaxSplits;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [IDX_W-1:0]   mid_in;
  logic [IDX_W-1:0]   mid_q;
  logic [AddrW-1:0]   raddr;
  logic [AddrW-1:0]   waddr;
  logic               we;
  logic [VALUE_W-1:0] rdata;
  logic               valid_q;
  item_t              item_q;

  // Probe the middle of the current bounds
  assign mid_in = IDX_W'(({1'b0, item_i.lo} + {1'b0, item_i.hi}) >> 1);
  assign raddr  = AddrW'(AddrW'(item_i.row) * AddrW'(MaxSplits) + AddrW'(mid_in));

  // Write beats update this copy as they pass
  assign waddr = AddrW'(AddrW'(item_i.row) * AddrW'(MaxSplits) + AddrW'(item_i.slot));
  assign we    = valid_i && (item_i.cmd == CMD_WRITE) && item_i.wr_ok;

  stbl_ram #(
    .Width (VALUE_W),
    .Depth (Depth)
  ) u_copy (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_i.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the item while its probe is read
  always_ff @(posedge clk_i) begin
    item_q <= item_i;
    mid_q  <= mid_in;
  end

  // Narrow the bounds with the probed split
  always_comb begin
    item_o = item_q;
    if (item_q.lo < item_q.hi) begin
      if (item_q.value <= $signed(rdata)) begin
        item_o.hi = mid_q;
      end else begin
        item_o.lo = IDX_W'({1'b0, mid_q} + 8'd1);
      end
    end
  end

  assign valid_o = valid_q;

endmodule

// File: src/split_table_bin_lookup_top.sv
// Binary-search bucketizer over a split table of MaxFeatures rows by MaxSplits
// signed Q16.16 splits. One command beat is taken every cycle; busy is never
// raised. Each beat gives one result beat, strobed by res_valid_o for exactly one
// cycle, once the beat has passed the search stages and the result register;
// the receiver cannot stall, so it must take every result as it comes. The
// search does one halving of the bounds per pipeline stage,
// each stage with its own copy of the table so every probe has its own read port,
// plus a head copy for the last split and the value-from-bin reads. A write beat
// updates each copy as it passes that copy's stage, so later lookups always see
// it. The table is not cleared at reset; entries must be written before they are
// read. splits_in_use applies to beats accepted after the write.
module split_table_bin_lookup_top import stbl_pkg::*; #(
  parameter int MaxFeatures = MAX_FEATURES,
  parameter int MaxSplits   = MAX_SPLITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  // result channel
  output logic             res_valid_o,
  output res_t             res_o,
  // configuration channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int Depth  = MaxFeatures * MaxSplits;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int NumLvl = (MaxSplits > 1) ? $clog2(MaxSplits) : 1;
  localparam int NumRow = 1 << ROW_W;

  logic [CFG_W-1:0]   splits_q;
  logic [IDX_W-1:0]   n_act;
  logic [ROW_W-1:0]   row_lut [NumRow];
  logic               bin_in_range;
  logic [IDX_W-1:0]   head_idx;
  logic [AddrW-1:0]   head_raddr;
  logic [AddrW-1:0]   head_waddr;
  logic               head_we;
  logic [VALUE_W-1:0] head_rdata;
  logic signed [VALUE_W:0] head_inc;
  item_t              entry_item;
  logic               s_valid [NumLvl+1];
  item_t              s_item  [NumLvl+1];
  logic               st_valid [NumLvl];
  item_t              st_item  [NumLvl];
  item_t              patched;
  item_t              last;
  res_t               res_d;
  res_t               res_q;
  logic               res_valid_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      splits_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      splits_q <= cfg_data_i;
    end
  end

  // Clamp the split count to the table width
  assign n_act = (int'(splits_q) > MaxSplits) ? IDX_W'(MaxSplits) : IDX_W'(splits_q);

  // Feature to row, wrapped at the row count
  for (genvar g = 0; g < NumRow; g++) begin : g_row
    assign row_lut[g] = ROW_W'(g % MaxFeatures);
  end

  // Build the entering item
  always_comb begin
    entry_item         = '0;
    entry_item.cmd     = req_i.cmd;
    entry_item.row     = row_lut[req_i.feature];
    entry_item.slot    = req_i.slot;
    entry_item.wr_ok   = int'(req_i.slot) < MaxSplits;
    entry_item.bin_in  = req_i.bin_in;
    entry_item.value   = req_i.value;
    entry_item.missing = req_i.value_missing;
    entry_item.n       = n_act;
    entry_item.lo      = '0;
    entry_item.hi      = (n_act == '0) ? '0 : IDX_W'(n_act - IDX_W'(1));
    entry_item.status  = ST_OK;
  end
  assign s_item[0]  = entry_item;
  assign s_valid[0] = start && !busy;

  // Head read: the queried bin when it is a split, else the last split
  assign bin_in_range = !req_i.bin_in[BIN_W-1] && ({1'b0, req_i.bin_in[IDX_W-1:0]} < {1'b0, n_act});
  assign head_idx     = (req_i.cmd == CMD_VALUE && bin_in_range) ?
                        req_i.bin_in[IDX_W-1:0] : s_item[0].hi;
  assign head_raddr   = AddrW'(AddrW'(s_item[0].row) * AddrW'(MaxSplits) + AddrW'(head_idx));
  assign head_waddr   = AddrW'(AddrW'(s_item[0].row) * AddrW'(MaxSplits) +
                        AddrW'(s_item[0].slot));
  assign head_we      = s_valid[0] && (req_i.cmd == CMD_WRITE) && s_item[0].wr_ok;

  stbl_ram #(
    .Width (VALUE_W),
    .Depth (Depth)
  ) u_head (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (req_i.value),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  // Search stages
  for (genvar k = 0; k < NumLvl; k++) begin : g_lvl
    stbl_stage #(
      .MaxFeatures (MaxFeatures),
      .MaxSplits   (MaxSplits)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s_valid[k]),
      .item_i  (s_item[k]),
      .valid_o (st_valid[k]),
      .item_o  (st_item[k])
    );
    assign s_valid[k+1] = st_valid[k];
    if (k == 0) begin : g_first
      assign s_item[k+1] = patched;
    end else begin : g_rest
      assign s_item[k+1] = st_item[k];
    end
  end

  // Fold in the head read: overflow test and the value-from-bin answer
  assign head_inc = $signed({head_rdata[VALUE_W-1], head_rdata}) +
                    $signed({Q_ONE[VALUE_W-1], Q_ONE});
  always_comb begin
    patched      = st_item[0];
    patched.over = st_item[0].value > $signed(head_rdata);
    if (st_item[0].bin_in < 0) begin
      patched.nan = 1'b1;
    end else if (st_item[0].n == '0) begin
      patched.status = ST_EMPTY;
    end else if ({1'b0, st_item[0].bin_in} < {2'b00, st_item[0].n}) begin
      patched.val_res = $signed(head_rdata);
    end else if ({1'b0, st_item[0].bin_in} == {2'b00, st_item[0].n}) begin
      patched.val_res = (head_inc > $signed({1'b0, Q_MAX})) ?
                        Q_MAX : head_inc[VALUE_W-1:0];
    end else begin
      patched.status = ST_RANGE;
    end
  end

  // Form the result beat
  assign last = s_item[NumLvl];
  always_comb begin
    res_d = '0;
    res_d.status = ST_OK;
    case (last.cmd)
      CMD_BIN: begin
        if (last.missing) begin
          res_d.bin_out = BIN_NAN;
        end else if (last.n == '0) begin
          res_d.status = ST_EMPTY;
        end else if (last.over) begin
          res_d.bin_out = BIN_W'(last.n);
        end else begin
          res_d.bin_out = BIN_W'(last.hi);
        end
      end
      CMD_VALUE: begin
        res_d.value_out    = last.val_res;
        res_d.value_is_nan = last.nan;
        res_d.status       = last.status;
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Result register: strobe for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s_valid[NumLvl];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
